// ===== sv/srwm_pkg.sv =====
// Package: shared types and constants for the SMBus word-read master.
`timescale 1ns / 1ps

package srwm_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT    = 1'b1;

    localparam logic [6:0] DEV_ADDR_RESET    = 7'd0;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_TEST = 2'd2;

    localparam logic [15:0]        WORD_FAIL   = 16'hFFFF;
    localparam logic signed [17:0] TEMP_OFFSET = 18'sd27315;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST0  = 5'd1,
        PH_ST1  = 5'd2,
        PH_ST2  = 5'd3,
        PH_TX_A = 5'd4,
        PH_TX_B = 5'd5,
        PH_TX_C = 5'd6,
        PH_AK_A = 5'd7,
        PH_AK_P = 5'd8,
        PH_AK_C = 5'd9,
        PH_RX_A = 5'd10,
        PH_RX_B = 5'd11,
        PH_RA_A = 5'd12,
        PH_RA_B = 5'd13,
        PH_RA_C = 5'd14,
        PH_SP0  = 5'd15,
        PH_SP1  = 5'd16,
        PH_FP0  = 5'd17,
        PH_FP1  = 5'd18
    } t_phase;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic               scl_out;
        logic               sda_out;
        logic               busy_res;
        logic               done_res;
        logic               status;
        logic [15:0]        read_word;
        logic signed [17:0] temp_centi_c;
    } t_result;

endpackage

// ===== sv/srwm_core.sv =====
// Bus sequencer: phase register, shift/count state and per-tick pin/result logic.
`timescale 1ns / 1ps

module srwm_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_reg_addr,
    input  logic                 i_sda_in,
    input  srwm_pkg::t_cfg_wr    i_cfg,
    output srwm_pkg::t_result    o_res
);

    logic [6:0]       r_dev_addr;
    logic [7:0]       r_ack_timeout;
    srwm_pkg::t_phase r_phase, n_phase, eff_phase;
    logic [3:0]       r_bit_count, n_bit_count, eff_bit_count;
    logic [7:0]       r_shift, n_shift, eff_shift;
    logic [1:0]       r_byte_idx, n_byte_idx, eff_byte_idx;
    logic [7:0]       r_low, n_low;
    logic [7:0]       r_high, n_high;
    logic [7:0]       r_wait, n_wait, eff_wait;
    logic [7:0]       r_held, n_held, eff_held;
    logic             r_test, n_test, eff_test;

    logic        start;
    logic [3:0]  bc_inc;
    logic [15:0] word_cat;

    // A start command in idle latches operands and runs the first start tick now.
    assign start = (r_phase == srwm_pkg::PH_IDLE) &&
                   ((i_command == srwm_pkg::CMD_READ) || (i_command == srwm_pkg::CMD_TEST));

    always_comb begin
        eff_phase     = start ? srwm_pkg::PH_ST0 : r_phase;
        eff_shift     = start ? {r_dev_addr, 1'b0} : r_shift;
        eff_bit_count = start ? 4'd0 : r_bit_count;
        eff_byte_idx  = start ? 2'd0 : r_byte_idx;
        eff_wait      = start ? 8'd0 : r_wait;
        eff_held      = start ? i_reg_addr : r_held;
        eff_test      = start ? (i_command == srwm_pkg::CMD_TEST) : r_test;
    end

    assign bc_inc   = eff_bit_count + 4'd1;
    assign word_cat = {r_high, r_low};

    // next state
    always_comb begin
        n_phase     = eff_phase;
        n_shift     = eff_shift;
        n_bit_count = eff_bit_count;
        n_byte_idx  = eff_byte_idx;
        n_wait      = eff_wait;
        n_held      = eff_held;
        n_test      = eff_test;
        n_low       = r_low;
        n_high      = r_high;
        case (eff_phase)
            srwm_pkg::PH_IDLE: begin
            end
            srwm_pkg::PH_ST0: n_phase = srwm_pkg::PH_ST1;
            srwm_pkg::PH_ST1: n_phase = srwm_pkg::PH_ST2;
            srwm_pkg::PH_ST2: begin
                n_bit_count = 4'd0;
                n_phase     = srwm_pkg::PH_TX_A;
            end
            srwm_pkg::PH_TX_A: n_phase = srwm_pkg::PH_TX_B;
            srwm_pkg::PH_TX_B: n_phase = srwm_pkg::PH_TX_C;
            srwm_pkg::PH_TX_C: begin
                n_shift     = {eff_shift[6:0], 1'b0};
                n_bit_count = bc_inc;
                if (bc_inc >= 4'd8) begin
                    n_wait  = 8'd0;
                    n_phase = srwm_pkg::PH_AK_A;
                end else begin
                    n_phase = srwm_pkg::PH_TX_A;
                end
            end
            srwm_pkg::PH_AK_A: n_phase = srwm_pkg::PH_AK_P;
            srwm_pkg::PH_AK_P: begin
                if (!i_sda_in) begin
                    n_phase = srwm_pkg::PH_AK_C;
                end else if (eff_wait == r_ack_timeout) begin
                    n_phase = srwm_pkg::PH_FP0;
                end else begin
                    n_wait = eff_wait + 8'd1;
                end
            end
            srwm_pkg::PH_AK_C: begin
                n_bit_count = 4'd0;
                if (eff_test) begin
                    n_phase = srwm_pkg::PH_SP0;
                end else if (eff_byte_idx == 2'd0) begin
                    n_shift    = eff_held;
                    n_byte_idx = 2'd1;
                    n_phase    = srwm_pkg::PH_TX_A;
                end else if (eff_byte_idx == 2'd1) begin
                    // repeated start, address with read
                    n_shift    = {r_dev_addr, 1'b1};
                    n_byte_idx = 2'd2;
                    n_phase    = srwm_pkg::PH_ST0;
                end else begin
                    n_byte_idx = 2'd0;
                    n_shift    = 8'd0;
                    n_phase    = srwm_pkg::PH_RX_A;
                end
            end
            srwm_pkg::PH_RX_A: n_phase = srwm_pkg::PH_RX_B;
            srwm_pkg::PH_RX_B: begin
                n_shift     = {eff_shift[6:0], i_sda_in};
                n_bit_count = bc_inc;
                n_phase     = (bc_inc >= 4'd8) ? srwm_pkg::PH_RA_A : srwm_pkg::PH_RX_A;
            end
            srwm_pkg::PH_RA_A: n_phase = srwm_pkg::PH_RA_B;
            srwm_pkg::PH_RA_B: n_phase = srwm_pkg::PH_RA_C;
            srwm_pkg::PH_RA_C: begin
                if (eff_byte_idx == 2'd0) n_low = eff_shift;
                if (eff_byte_idx == 2'd1) n_high = eff_shift;
                if (eff_byte_idx >= 2'd2) begin
                    n_phase = srwm_pkg::PH_SP0;
                end else begin
                    n_byte_idx  = eff_byte_idx + 2'd1;
                    n_bit_count = 4'd0;
                    n_shift     = 8'd0;
                    n_phase     = srwm_pkg::PH_RX_A;
                end
            end
            srwm_pkg::PH_SP0: n_phase = srwm_pkg::PH_SP1;
            srwm_pkg::PH_SP1: n_phase = srwm_pkg::PH_IDLE;
            srwm_pkg::PH_FP0: n_phase = srwm_pkg::PH_FP1;
            srwm_pkg::PH_FP1: n_phase = srwm_pkg::PH_IDLE;
            default:          n_phase = srwm_pkg::PH_IDLE;
        endcase
    end

    // outputs for this tick
    always_comb begin
        o_res              = '0;
        o_res.scl_out      = 1'b1;
        o_res.sda_out      = 1'b1;
        o_res.busy_res     = 1'b1;
        case (eff_phase)
            srwm_pkg::PH_IDLE: o_res.busy_res = 1'b0;
            srwm_pkg::PH_ST0: begin
            end
            srwm_pkg::PH_ST1: o_res.sda_out = 1'b0;
            srwm_pkg::PH_ST2: begin
                o_res.scl_out = 1'b0;
                o_res.sda_out = 1'b0;
            end
            srwm_pkg::PH_TX_A, srwm_pkg::PH_TX_C: begin
                o_res.scl_out = 1'b0;
                o_res.sda_out = eff_shift[7];
            end
            srwm_pkg::PH_TX_B: o_res.sda_out = eff_shift[7];
            srwm_pkg::PH_AK_A, srwm_pkg::PH_AK_C, srwm_pkg::PH_RX_A:
                o_res.scl_out = 1'b0;
            srwm_pkg::PH_AK_P, srwm_pkg::PH_RX_B: begin
            end
            srwm_pkg::PH_RA_A, srwm_pkg::PH_RA_C: begin
                o_res.scl_out = 1'b0;
                o_res.sda_out = (eff_byte_idx >= 2'd2);  // nack on PEC
            end
            srwm_pkg::PH_RA_B: o_res.sda_out = (eff_byte_idx >= 2'd2);
            srwm_pkg::PH_SP0, srwm_pkg::PH_FP0: o_res.sda_out = 1'b0;
            srwm_pkg::PH_SP1: begin
                o_res.done_res = 1'b1;
                if (!eff_test) begin
                    o_res.read_word = word_cat;
                    if (word_cat == srwm_pkg::WORD_FAIL) begin
                        o_res.temp_centi_c = -srwm_pkg::TEMP_OFFSET;
                    end else begin
                        o_res.temp_centi_c = $signed({1'b0, word_cat, 1'b0})
                                             - srwm_pkg::TEMP_OFFSET;
                    end
                end
            end
            srwm_pkg::PH_FP1: begin
                o_res.done_res     = 1'b1;
                o_res.status       = 1'b1;
                o_res.read_word    = srwm_pkg::WORD_FAIL;
                o_res.temp_centi_c = -srwm_pkg::TEMP_OFFSET;
            end
            default: o_res.busy_res = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= srwm_pkg::DEV_ADDR_RESET;
            r_ack_timeout <= srwm_pkg::ACK_TIMEOUT_RESET;
            r_phase       <= srwm_pkg::PH_IDLE;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_byte_idx    <= '0;
            r_low         <= '0;
            r_high        <= '0;
            r_wait        <= '0;
            r_held        <= '0;
            r_test        <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.index)
                    srwm_pkg::CFG_DEVICE_ADDRESS: r_dev_addr    <= i_cfg.data[6:0];
                    srwm_pkg::CFG_ACK_TIMEOUT:    r_ack_timeout <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (i_en) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_shift     <= n_shift;
                r_byte_idx  <= n_byte_idx;
                r_low       <= n_low;
                r_high      <= n_high;
                r_wait      <= n_wait;
                r_held      <= n_held;
                r_test      <= n_test;
            end
        end
    end

endmodule

// ===== sv/srwm_outbuf.sv =====
// Two-entry result buffer that decouples the sequencer from a stalling receiver.
`timescale 1ns / 1ps

module srwm_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  srwm_pkg::t_result    i_data,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output srwm_pkg::t_result    o_data
);

    srwm_pkg::t_result r_data [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;
    logic              pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_rptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (pop)    r_rptr <= ~r_rptr;
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/smbus_read_word_master.sv =====
// Top level: SMBus word-read master with tick input channel and result channel.
`timescale 1ns / 1ps

// Each input beat is one bus delay tick carrying a command, a register byte
// and the sampled SDA level. Each accepted beat yields exactly one result beat
// with the SCL/SDA drive levels for that tick (1 releases, 0 pulls low), busy,
// done, status, the word read and its temperature in hundredths of a degree C.
// Command 1 starts a word read, command 2 an address test; starts given while
// busy are ignored. A transaction ends with one done beat; an ack timeout
// reports status 1 and word 0xFFFF.
// Each result beat is buffered on acceptance, behind any earlier results.
// Throughput is one beat per cycle while o_in_ready is high; the sequencer
// steps once per accepted beat. Results go through a two-entry buffer, so
// input is still taken while one result waits; when both entries are held
// by a stalled receiver, o_in_ready drops until a result is taken.
// The config port writes device_address (index 0) and ack_timeout (index 1)
// at any edge with i_cfg_we high; write only while idle.
// Reset (synchronous, active low) returns the sequencer to idle, empties the
// result buffer and sets device_address 0, ack_timeout 250.

module smbus_read_word_master (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_command,
    input  logic [7:0]                     i_reg_addr,
    input  logic                           i_sda_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_scl_out,
    output logic                           o_sda_out,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_status,
    output logic [15:0]                    o_read_word,
    output logic signed [17:0]             o_temp_centi_c,
    input  logic                           i_cfg_we,
    input  logic [srwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srwm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    srwm_pkg::t_cfg_wr cfg;
    srwm_pkg::t_result step_res;
    srwm_pkg::t_result out_res;
    logic              accept;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    assign accept = i_in_valid && o_in_ready;

    srwm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (accept),
        .i_command  (i_command),
        .i_reg_addr (i_reg_addr),
        .i_sda_in   (i_sda_in),
        .i_cfg      (cfg),
        .o_res      (step_res)
    );

    srwm_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (step_res),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_res)
    );

    assign o_scl_out      = out_res.scl_out;
    assign o_sda_out      = out_res.sda_out;
    assign o_busy_res     = out_res.busy_res;
    assign o_done_res     = out_res.done_res;
    assign o_status       = out_res.status;
    assign o_read_word    = out_res.read_word;
    assign o_temp_centi_c = out_res.temp_centi_c;

endmodule

// ===== sv/srwm_checker.sv =====
// Port-level checker for the SMBus word-read master, bound to the top level.
`timescale 1ns / 1ps

module srwm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_scl_out,
    input logic               o_sda_out,
    input logic               o_busy_res,
    input logic               o_done_res,
    input logic               o_status,
    input logic [15:0]        o_read_word,
    input logic signed [17:0] o_temp_centi_c
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_word)
            && $stable(o_temp_centi_c) && $stable(o_done_res) && $stable(o_scl_out)
            && $stable(o_sda_out))
        else $error("result beat changed while stalled");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_busy_res)
        else $error("done without busy");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |-> !o_status && (o_read_word == 16'd0)
            && (o_temp_centi_c == 18'sd0))
        else $error("result fields nonzero outside done");

    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> (o_read_word == srwm_pkg::WORD_FAIL)
            && (o_temp_centi_c == -srwm_pkg::TEMP_OFFSET))
        else $error("timeout result values wrong");

    a_not_busy_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_scl_out && o_sda_out)
        else $error("bus driven while idle");

endmodule

bind smbus_read_word_master srwm_checker u_srwm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_scl_out      (o_scl_out),
    .o_sda_out      (o_sda_out),
    .o_busy_res     (o_busy_res),
    .o_done_res     (o_done_res),
    .o_status       (o_status),
    .o_read_word    (o_read_word),
    .o_temp_centi_c (o_temp_centi_c)
);

// ===== tb/smbus_read_word_master_checker.sv =====
// Checker: predicts every result beat of the SMBus word-read master and compares.
`timescale 1ns / 1ps

module smbus_read_word_master_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [1:0]                      i_command,
    input  logic [7:0]                      i_reg_addr,
    input  logic                            i_sda_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_scl_out,
    input  logic                            i_sda_out,
    input  logic                            i_busy_res,
    input  logic                            i_done_res,
    input  logic                            i_status,
    input  logic [15:0]                     i_read_word,
    input  logic signed [17:0]              i_temp_centi_c,
    input  logic                            i_cfg_we,
    input  logic [srwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srwm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output logic                            o_bus_idle
);

    import srwm_pkg::*;

    // bus sequencer copy
    t_phase     bus_phase;
    logic [6:0] dev_addr;
    logic [7:0] ack_limit;
    logic [3:0] bit_cnt;
    logic [7:0] shift_reg;
    logic [1:0] byte_idx;
    logic [7:0] low_byte;
    logic [7:0] high_byte;
    logic [7:0] poll_cnt;
    logic [7:0] held_reg;
    logic       test_only;

    t_result    tick_q[$];
    t_result    beat_got;
    t_result    beat_want;
    int         fail_cnt = 0;

    task automatic predict_tick(input logic [1:0] cmd, input logic [7:0] reg_byte,
                                input logic sda, output t_result res);
        int word_full;
        res          = '0;
        res.scl_out  = 1'b1;
        res.sda_out  = 1'b1;
        res.busy_res = 1'b1;

        // a start only counts while idle; the start tick itself is the first start tick
        if (bus_phase == PH_IDLE && (cmd == CMD_READ || cmd == CMD_TEST)) begin
            held_reg  = reg_byte;
            test_only = (cmd == CMD_TEST);
            shift_reg = {dev_addr, 1'b0};
            bit_cnt   = '0;
            byte_idx  = '0;
            poll_cnt  = '0;
            bus_phase = PH_ST0;
        end

        case (bus_phase)
            PH_IDLE: res.busy_res = 1'b0;
            PH_ST0:  bus_phase = PH_ST1;
            PH_ST1: begin
                res.sda_out = 1'b0;
                bus_phase   = PH_ST2;
            end
            PH_ST2: begin
                res.scl_out = 1'b0;
                res.sda_out = 1'b0;
                bit_cnt     = '0;
                bus_phase   = PH_TX_A;
            end
            PH_TX_A, PH_TX_B, PH_TX_C: begin
                res.sda_out = shift_reg[7];
                if (bus_phase == PH_TX_A) begin
                    res.scl_out = 1'b0;
                    bus_phase   = PH_TX_B;
                end else if (bus_phase == PH_TX_B) begin
                    bus_phase = PH_TX_C;
                end else begin
                    res.scl_out = 1'b0;
                    shift_reg   = {shift_reg[6:0], 1'b0};
                    bit_cnt     = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8) begin
                        poll_cnt  = '0;
                        bus_phase = PH_AK_A;
                    end else begin
                        bus_phase = PH_TX_A;
                    end
                end
            end
            PH_AK_A: begin
                res.scl_out = 1'b0;
                bus_phase   = PH_AK_P;
            end
            PH_AK_P: begin
                if (!sda) bus_phase = PH_AK_C;
                else if (poll_cnt == ack_limit) bus_phase = PH_FP0;
                else poll_cnt = poll_cnt + 8'd1;
            end
            PH_AK_C: begin
                res.scl_out = 1'b0;
                bit_cnt     = '0;
                if (test_only) begin
                    bus_phase = PH_SP0;
                end else if (byte_idx == 2'd0) begin
                    shift_reg = held_reg;
                    byte_idx  = 2'd1;
                    bus_phase = PH_TX_A;
                end else if (byte_idx == 2'd1) begin
                    // repeated start, then the address with the read bit
                    shift_reg = {dev_addr, 1'b1};
                    byte_idx  = 2'd2;
                    bus_phase = PH_ST0;
                end else begin
                    byte_idx  = 2'd0;
                    shift_reg = '0;
                    bus_phase = PH_RX_A;
                end
            end
            PH_RX_A: begin
                res.scl_out = 1'b0;
                bus_phase   = PH_RX_B;
            end
            PH_RX_B: begin
                shift_reg = {shift_reg[6:0], sda};
                bit_cnt   = bit_cnt + 4'd1;
                bus_phase = (bit_cnt >= 4'd8) ? PH_RA_A : PH_RX_A;
            end
            PH_RA_A, PH_RA_B, PH_RA_C: begin
                // ack low and high bytes, nack the PEC byte
                res.sda_out = (byte_idx >= 2'd2);
                if (bus_phase == PH_RA_A) begin
                    res.scl_out = 1'b0;
                    bus_phase   = PH_RA_B;
                end else if (bus_phase == PH_RA_B) begin
                    bus_phase = PH_RA_C;
                end else begin
                    res.scl_out = 1'b0;
                    if (byte_idx == 2'd0) low_byte = shift_reg;
                    else if (byte_idx == 2'd1) high_byte = shift_reg;
                    if (byte_idx >= 2'd2) begin
                        bus_phase = PH_SP0;
                    end else begin
                        byte_idx  = byte_idx + 2'd1;
                        bit_cnt   = '0;
                        shift_reg = '0;
                        bus_phase = PH_RX_A;
                    end
                end
            end
            PH_SP0: begin
                res.sda_out = 1'b0;
                bus_phase   = PH_SP1;
            end
            PH_SP1: begin
                res.done_res = 1'b1;
                if (!test_only) begin
                    res.read_word = {high_byte, low_byte};
                    if (res.read_word == WORD_FAIL) begin
                        res.temp_centi_c = -TEMP_OFFSET;
                    end else begin
                        word_full        = int'(res.read_word) * 2 - int'(TEMP_OFFSET);
                        res.temp_centi_c = word_full[17:0];
                    end
                end
                bus_phase = PH_IDLE;
            end
            PH_FP0: begin
                res.sda_out = 1'b0;
                bus_phase   = PH_FP1;
            end
            PH_FP1: begin
                res.done_res     = 1'b1;
                res.status       = 1'b1;
                res.read_word    = WORD_FAIL;
                res.temp_centi_c = -TEMP_OFFSET;
                bus_phase        = PH_IDLE;
            end
            default: begin
                res.busy_res = 1'b0;
                bus_phase    = PH_IDLE;
            end
        endcase
    endtask

    function automatic string fmt_result(input t_result r);
        return $sformatf("scl=%b sda=%b busy=%b done=%b status=%b word=%h temp=%0d",
                         r.scl_out, r.sda_out, r.busy_res, r.done_res, r.status,
                         r.read_word, r.temp_centi_c);
    endfunction

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) $display("%t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dev_addr  = DEV_ADDR_RESET;
            ack_limit = ACK_TIMEOUT_RESET;
            bus_phase = PH_IDLE;
            bit_cnt   = '0;
            shift_reg = '0;
            byte_idx  = '0;
            low_byte  = '0;
            high_byte = '0;
            poll_cnt  = '0;
            held_reg  = '0;
            test_only = 1'b0;
            tick_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DEVICE_ADDRESS) dev_addr = i_cfg_data[6:0];
                else if (i_cfg_index == CFG_ACK_TIMEOUT) ack_limit = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                beat_got = {i_scl_out, i_sda_out, i_busy_res, i_done_res, i_status,
                            i_read_word, i_temp_centi_c};
                if (tick_q.size() == 0) begin
                    note_failure({"result beat with nothing outstanding: ",
                                  fmt_result(beat_got)});
                end else begin
                    beat_want = tick_q.pop_front();
                    if (beat_got.scl_out !== beat_want.scl_out
                            || beat_got.sda_out !== beat_want.sda_out
                            || beat_got.busy_res !== beat_want.busy_res
                            || beat_got.done_res !== beat_want.done_res
                            || beat_got.status !== beat_want.status
                            || beat_got.read_word !== beat_want.read_word
                            || beat_got.temp_centi_c !== beat_want.temp_centi_c)
                        note_failure({"mismatch: expected ", fmt_result(beat_want),
                                      " got ", fmt_result(beat_got)});
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_tick(i_command, i_reg_addr, i_sda_in, beat_want);
                tick_q.push_back(beat_want);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= tick_q.size();
        o_bus_idle   <= (bus_phase == PH_IDLE);
    end

endmodule

// ===== tb/smbus_read_word_master_test.sv =====
// Testbench top: drives bus ticks and config writes into the SMBus word-read master.
`timescale 1ns / 1ps

module smbus_read_word_master_test;

    import srwm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_command   = CMD_TICK;
    logic [7:0]            i_reg_addr  = 8'h00;
    logic                  i_sda_in    = 1'b1;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_scl_out;
    logic                  o_sda_out;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic                  o_status;
    logic [15:0]           o_read_word;
    logic signed [17:0]    o_temp_centi_c;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_DEVICE_ADDRESS;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int   fail_count;
    int   pending;
    logic bus_idle;

    int   burst_left  = 0;
    int   items_sent  = 0;
    int   cur_timeout = int'(ACK_TIMEOUT_RESET);
    int   stall_left  = 0;
    int   stall_mode  = 0;
    int   mode_left   = 0;
    logic line_q[$];     // SDA levels the target shows, one per tick

    smbus_read_word_master u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_reg_addr     (i_reg_addr),
        .i_sda_in       (i_sda_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_scl_out      (o_scl_out),
        .o_sda_out      (o_sda_out),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_status       (o_status),
        .o_read_word    (o_read_word),
        .o_temp_centi_c (o_temp_centi_c),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    smbus_read_word_master_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_reg_addr     (i_reg_addr),
        .i_sda_in       (i_sda_in),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_scl_out      (o_scl_out),
        .i_sda_out      (o_sda_out),
        .i_busy_res     (o_busy_res),
        .i_done_res     (o_done_res),
        .i_status       (o_status),
        .i_read_word    (o_read_word),
        .i_temp_centi_c (o_temp_centi_c),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_bus_idle     (bus_idle)
    );

    always #10 i_clk = ~i_clk;

    // receiver: stretches of no stalls, light stalls and heavy stalls
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 300);
        end
        mode_left--;
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (stall_mode != 0
                     && $urandom_range(0, 9) < ((stall_mode == 1) ? 2 : 5)) begin
            stall_left = $urandom_range(0, 7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [1:0] noise_cmd();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return CMD_TICK;
        if (r == 6) return CMD_READ;
        if (r == 7) return CMD_TEST;
        return CMD_UNUSED;
    endfunction

    // one tick beat; the sender runs in bursts with random gaps between them
    task automatic send_tick(input logic [1:0] cmd, input logic [7:0] reg_byte,
                             input logic sda);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_reg_addr <= reg_byte;
        i_sda_in   <= sda;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    function automatic void add_free(input int n);
        repeat (n) line_q.push_back($urandom_range(0, 1) != 0);
    endfunction

    // 8 bits out plus the ack clock; returns 1 when the target never acks
    function automatic bit add_sent_byte(input bit time_out, input bit long_poll);
        int polls;
        add_free(25);
        if (time_out) begin
            repeat (cur_timeout + 1) line_q.push_back(1'b1);
            add_free(2);
            return 1'b1;
        end
        if (long_poll) polls = cur_timeout;
        else if ($urandom_range(0, 3) == 0)
            polls = $urandom_range(0, (cur_timeout < 5) ? cur_timeout : 5);
        else polls = 0;
        repeat (polls) line_q.push_back(1'b1);
        line_q.push_back(1'b0);
        add_free(1);
        return 1'b0;
    endfunction

    function automatic void add_read_byte(input logic [7:0] value);
        for (int i = 7; i >= 0; i--) begin
            add_free(1);
            line_q.push_back(value[i]);
        end
        add_free(3);
    endfunction

    // well-formed transaction from idle; fail_at picks the ack that times out
    task automatic run_transaction(input logic [1:0] kind, input logic [7:0] reg_byte,
                                   input logic [15:0] word, input int fail_at,
                                   input bit long_poll);
        bit         stopped;
        logic [1:0] cmd;
        logic [7:0] reg_now;
        line_q.delete();
        add_free(3);
        stopped = add_sent_byte(fail_at == 0, long_poll);
        if (kind == CMD_READ && !stopped) begin
            stopped = add_sent_byte(fail_at == 1, long_poll);
            if (!stopped) begin
                add_free(3);
                stopped = add_sent_byte(fail_at == 2, long_poll);
            end
            if (!stopped) begin
                add_read_byte(word[7:0]);
                add_read_byte(word[15:8]);
                add_read_byte(8'($urandom_range(0, 255)));
            end
        end
        if (!stopped) add_free(2);
        cmd     = kind;
        reg_now = reg_byte;
        while (line_q.size() != 0) begin
            send_tick(cmd, reg_now, line_q.pop_front());
            // later beats carry random commands, ignored while busy
            cmd     = noise_cmd();
            reg_now = 8'($urandom_range(0, 255));
        end
    endtask

    // run ticks until the sequencer is back in idle
    task automatic drain_bus();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (!bus_idle) begin
            send_tick(CMD_TICK, 8'($urandom_range(0, 255)), $urandom_range(0, 1) != 0);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic settle();
        drain_bus();
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic configure(input logic [6:0] addr, input logic [7:0] timeout_ticks);
        logic pad;
        pad = $urandom_range(0, 1) != 0;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEVICE_ADDRESS;
        i_cfg_data  <= {pad, addr};
        @(posedge i_clk);
        i_cfg_index <= CFG_ACK_TIMEOUT;
        i_cfg_data  <= timeout_ticks;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_timeout = int'(timeout_ticks);
    endtask

    initial begin
        int phase_end;
        int pick;
        int fail_at;
        logic [1:0] kind;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle ticks, unused command code, reset config
        send_tick(CMD_TICK, 8'h00, 1'b0);
        send_tick(CMD_TICK, 8'hFF, 1'b1);
        send_tick(CMD_UNUSED, 8'hA5, 1'b0);
        send_tick(CMD_UNUSED, 8'h5A, 1'b1);
        // all-ones word still reports ok
        run_transaction(CMD_READ, 8'hFF, 16'hFFFF, -1, 1'b0);
        run_transaction(CMD_TEST, 8'h3C, 16'h0000, -1, 1'b0);

        // zero tolerance: a single high sample is a timeout
        settle();
        configure(7'd127, 8'd0);
        run_transaction(CMD_TEST, 8'h01, 16'h0000, 0, 1'b0);
        run_transaction(CMD_READ, 8'h80, 16'h1234, 1, 1'b0);
        run_transaction(CMD_READ, 8'h7F, 16'hBEEF, 2, 1'b0);
        run_transaction(CMD_TEST, 8'hC3, 16'h0000, -1, 1'b0);

        // widest tolerance: one poll past the limit times out
        settle();
        configure(7'h55, 8'd255);
        run_transaction(CMD_READ, 8'h12, 16'h8001, 0, 1'b0);

        for (int phase_no = 0; phase_no < 5; phase_no++) begin
            settle();
            case (phase_no)
                0: configure(7'($urandom_range(1, 126)), 8'($urandom_range(2, 10)));
                1: configure(7'd127, 8'd255);
                2: configure(7'd0, 8'd0);
                3: configure(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
                default: configure(7'($urandom_range(0, 127)), ACK_TIMEOUT_RESET);
            endcase
            phase_end = items_sent + 20;
            while (items_sent < phase_end) begin
                drain_bus();
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    kind    = (pick < 4) ? CMD_READ : CMD_TEST;
                    fail_at = -1;
                    if ($urandom_range(0, 9) == 0)
                        fail_at = (kind == CMD_READ) ? $urandom_range(0, 2) : 0;
                    run_transaction(kind, 8'($urandom_range(0, 255)),
                                    16'($urandom_range(0, 65535)), fail_at,
                                    $urandom_range(0, 19) == 0);
                end else begin
                    // noise: random commands and SDA, may start a broken transaction
                    repeat ($urandom_range(1, 30))
                        send_tick(noise_cmd(), 8'($urandom_range(0, 255)),
                                  $urandom_range(0, 1) != 0);
                end
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/srwm_pkg.sv
sv/srwm_core.sv
sv/srwm_outbuf.sv
sv/smbus_read_word_master.sv
sv/srwm_checker.sv
tb/smbus_read_word_master_checker.sv
tb/smbus_read_word_master_test.sv
